// File: hw/rtl/lzwdt_pkg.sv
package lzwdt_pkg;

  // default sizes
  localparam int DEF_TABLE_DEPTH = 4096;
  localparam int DEF_USAGE_BITS  = 16;

  // field widths
  localparam int REQ_W    = 3;
  localparam int CODE_W   = 12;
  localparam int CHAR_W   = 9;
  localparam int USE_W    = 16;
  localparam int BITS_W   = 4;
  localparam int STAT_W   = 2;
  localparam int LEN_W    = 5;

  // table seeded with one entry per byte value
  localparam int BYTE_VALUES  = 256;
  localparam int SEED_LEN     = 9;   // bit length of BYTE_VALUES
  localparam int MIN_BITS_RST = 9;

  localparam int IN_DATA_W  = 40;  // 33 bits of fields, padded to bytes
  localparam int OUT_DATA_W = 72;  // 66 bits of fields, padded to bytes

  // request kinds
  localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FIND    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_READ    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_BUMP    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_REPLACE = 3'd4;

  // result status
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

endpackage

// File: hw/rtl/lzwdt_ram.sv
module lzwdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/lzw_dictionary_table_unit.sv
// Insert, unknown and out-of-range requests go from accept straight to the result state;
//   read, bump and replace read the table entry first (bump and replace then write back).
// Find scans the table from the newest code down, one entry per cycle through
//   the table's read port, and stops at the first match or at code 1. Requests are
//   handled one at a time; the next is taken while a result waits. Reset (rst_n low,
//   synchronous): 256 entries, bytes seeded, min width 9.
module lzw_dictionary_table_unit #(
  parameter int TABLE_DEPTH = lzwdt_pkg::DEF_TABLE_DEPTH,
  parameter int USAGE_BITS  = lzwdt_pkg::DEF_USAGE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // cfg_data: min_code_bits
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lzwdt_pkg::BITS_W-1:0]      cfg_data,
  // in_tdata: prefix_code[11:0], char_value[20:12], code_in[32:21], zero pad
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lzwdt_pkg::IN_DATA_W-1:0]   in_tdata,
  // in_tuser: req_type[2:0]
  input  logic [lzwdt_pkg::REQ_W-1:0]       in_tuser,
  // out_tdata: found[0], code_out[12:1], prefix_out[24:13], char_out[33:25],
  //   usage_out[49:34], entry_count[61:50], code_bits[65:62], zero pad
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lzwdt_pkg::OUT_DATA_W-1:0]  out_tdata,
  // out_tuser: status[1:0]
  output logic [lzwdt_pkg::STAT_W-1:0]      out_tuser
);
  import lzwdt_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH);
  localparam int XW = (CW > CODE_W) ? CW : CODE_W;
  localparam int EW = CODE_W + CHAR_W + USAGE_BITS;

  typedef enum logic [1:0] {S_IDLE, S_RD, S_FIND, S_DONE} state_t;

  state_t                 state_r, state_nxt;
  logic [REQ_W-1:0]       req_r, req_nxt;
  logic [CODE_W-1:0]      pre_r, pre_nxt;
  logic [CHAR_W-1:0]      ch_r, ch_nxt;
  logic [CW-1:0]          addr_r, addr_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [LEN_W-1:0]       len_r, len_nxt;
  logic [BITS_W-1:0]      min_r;
  logic [BYTE_VALUES-1:0] vb_r, vb_nxt;
  logic                   rfound_r, rfound_nxt;
  logic [CODE_W-1:0]      rcode_r, rcode_nxt, rpre_r, rpre_nxt;
  logic [CHAR_W-1:0]      rch_r, rch_nxt;
  logic [USAGE_BITS-1:0]  ruse_r, ruse_nxt;
  logic [STAT_W-1:0]      rstat_r, rstat_nxt;
  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r;
  logic [STAT_W-1:0]      out_stat_r;

  // table memory port
  logic                   we, re;
  logic [CW-1:0]          waddr, raddr, cnt_inc;
  logic [EW-1:0]          wdata, rdata;

  // entry at addr_r, seeded value if a byte entry was never written
  logic                   is_low, seeded;
  logic [7:0]             vidx;
  logic [CODE_W-1:0]      e_pre;
  logic [CHAR_W-1:0]      e_ch;
  logic [USAGE_BITS-1:0]  e_use, use_mod;
  logic [CHAR_W-1:0]      ch_mod;

  logic [CODE_W-1:0]      f_pre, f_code;
  logic [CHAR_W-1:0]      f_ch;
  logic [REQ_W-1:0]       f_req;
  logic                   take, out_free;
  logic [LEN_W-1:0]       bits_w;

  lzwdt_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign f_pre  = in_tdata[11:0];
  assign f_ch   = in_tdata[20:12];
  assign f_code = in_tdata[32:21];
  assign f_req  = in_tuser;

  assign in_tready = (state_r == S_IDLE);
  assign take      = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;
  assign cnt_inc   = cnt_r + CW'(1);

  // entry decode with seed default
  assign is_low = (addr_r <= CW'(BYTE_VALUES));
  assign vidx   = 8'(addr_r - CW'(1));
  assign seeded = is_low && !vb_r[vidx];
  always_comb begin
    if (seeded) begin
      e_pre = '0;
      e_ch  = CHAR_W'(vidx);
      e_use = '0;
    end else begin
      e_pre = rdata[CODE_W-1:0];
      e_ch  = rdata[CODE_W +: CHAR_W];
      e_use = rdata[EW-1 -: USAGE_BITS];
    end
  end

  // bump saturates, replace swaps char
  assign use_mod = ((req_r == REQ_BUMP) && (e_use != '1)) ? e_use + USAGE_BITS'(1) : e_use;
  assign ch_mod  = (req_r == REQ_REPLACE) ? ch_r : e_ch;

  // main control
  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    pre_nxt    = pre_r;
    ch_nxt     = ch_r;
    addr_nxt   = addr_r;
    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    vb_nxt     = vb_r;
    rfound_nxt = rfound_r;
    rcode_nxt  = rcode_r;
    rpre_nxt   = rpre_r;
    rch_nxt    = rch_r;
    ruse_nxt   = ruse_r;
    rstat_nxt  = rstat_r;
    we         = 1'b0;
    waddr      = addr_r;
    wdata      = {use_mod, ch_mod, e_pre};
    re         = 1'b0;
    raddr      = addr_r;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          req_nxt    = f_req;
          pre_nxt    = f_pre;
          ch_nxt     = f_ch;
          rfound_nxt = 1'b0;
          rcode_nxt  = '0;
          rpre_nxt   = '0;
          rch_nxt    = '0;
          ruse_nxt   = '0;
          rstat_nxt  = ST_OK;
          state_nxt  = S_DONE;
          case (f_req)
            REQ_INSERT: begin
              if (cnt_r == CW'(TABLE_DEPTH - 1)) begin
                rstat_nxt = ST_FULL;
              end else begin
                we        = 1'b1;
                waddr     = cnt_inc;
                wdata     = {{USAGE_BITS{1'b0}}, f_ch, f_pre};
                cnt_nxt   = cnt_inc;
                rcode_nxt = CODE_W'(cnt_inc);
                if ((cnt_inc & (cnt_inc - CW'(1))) == '0) begin
                  len_nxt = len_r + LEN_W'(1);
                end
              end
            end
            REQ_FIND: begin
              re        = 1'b1;
              raddr     = cnt_r;
              addr_nxt  = cnt_r;
              state_nxt = S_FIND;
            end
            REQ_READ, REQ_BUMP, REQ_REPLACE: begin
              if ((f_code == '0) || (XW'(f_code) > XW'(cnt_r))) begin
                rstat_nxt = ST_RANGE;
              end else begin
                re        = 1'b1;
                raddr     = CW'(f_code);
                addr_nxt  = CW'(f_code);
                state_nxt = S_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        if (req_r != REQ_READ) begin
          we = 1'b1;
          if (is_low) begin
            vb_nxt[vidx] = 1'b1;
          end
        end
        rpre_nxt  = e_pre;
        rch_nxt   = ch_mod;
        ruse_nxt  = use_mod;
        state_nxt = S_DONE;
      end
      S_FIND: begin
        // compare entry at addr_r while fetching the next lower one
        if ((e_pre == pre_r) && (e_ch == ch_r)) begin
          rfound_nxt = 1'b1;
          rcode_nxt  = CODE_W'(addr_r);
          state_nxt  = S_DONE;
        end else if (addr_r == CW'(1)) begin
          state_nxt = S_DONE;
        end else begin
          re       = 1'b1;
          raddr    = addr_r - CW'(1);
          addr_nxt = addr_r - CW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign bits_w = (len_r > LEN_W'(min_r)) ? len_r : LEN_W'(min_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= CW'(BYTE_VALUES);
      len_r       <= LEN_W'(SEED_LEN);
      min_r       <= BITS_W'(MIN_BITS_RST);
      vb_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      vb_r    <= vb_nxt;
      if (cfg_valid && cfg_ready) begin
        min_r <= cfg_data;
      end
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    pre_r    <= pre_nxt;
    ch_r     <= ch_nxt;
    addr_r   <= addr_nxt;
    rfound_r <= rfound_nxt;
    rcode_r  <= rcode_nxt;
    rpre_r   <= rpre_nxt;
    rch_r    <= rch_nxt;
    ruse_r   <= ruse_nxt;
    rstat_r  <= rstat_nxt;
    if ((state_r == S_DONE) && out_free) begin
      out_data_r <= {6'd0, BITS_W'(bits_w), CODE_W'(cnt_r), USE_W'(ruse_r), rch_r,
                     rpre_r, rcode_r, rfound_r};
      out_stat_r <= rstat_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

  // entry count never drops below the seeded bytes
  a_cnt_floor: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r >= CW'(BYTE_VALUES)) else $error("entry count below seed");

  // count grows by at most one per cycle
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cnt_r == $past(cnt_r)) || (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("entry count jumped");

  // a full result only with a full table
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && (rstat_r == ST_FULL) |-> cnt_r == CW'(TABLE_DEPTH - 1))
    else $error("full status with room left");

  // a hit never reports code zero
  a_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && rfound_r |-> rcode_r != '0) else $error("hit on code zero");

endmodule

// File: verif/tb.sv
module tb;
  import lzwdt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = DEF_TABLE_DEPTH;
  localparam logic [USE_W-1:0] USE_MAX = '1;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 3'd5;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [CODE_W-1:0] prefix;
    logic [CHAR_W-1:0] chr;
    logic [CODE_W-1:0] code;
  } request_t;

  typedef struct packed {
    logic              found;
    logic [CODE_W-1:0] code_out;
    logic [CODE_W-1:0] prefix_out;
    logic [CHAR_W-1:0] char_out;
    logic [USE_W-1:0]  usage_out;
    logic [CODE_W-1:0] entry_count;
    logic [BITS_W-1:0] code_bits;
    logic [STAT_W-1:0] status;
  } answer_t;

  // directed row: request plus optional typed-in answer
  typedef struct packed {
    request_t rq;
    logic     has_ans;
    answer_t  ans;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [BITS_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [REQ_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STAT_W-1:0] out_tuser;

  lzw_dictionary_table_unit dut (.*);

  always #6 clk = ~clk;

  // shadow of the table
  logic [CODE_W-1:0] tbl_prefix [DEPTH];
  logic [CHAR_W-1:0] tbl_char [DEPTH];
  logic [USE_W-1:0]  tbl_usage [DEPTH];
  logic [CODE_W-1:0] tbl_count;
  logic [BITS_W-1:0] min_bits;

  answer_t answers_due[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;

  function automatic logic [BITS_W-1:0] width_of(logic [CODE_W-1:0] n);
    int b;
    b = 0;
    while (n != 0) begin
      n >>= 1;
      b++;
    end
    if (b < min_bits) b = min_bits;
    return b[BITS_W-1:0];
  endfunction

  function automatic void table_reset();
    for (int i = 0; i < DEPTH; i++) begin
      tbl_prefix[i] = '0;
      tbl_char[i] = (i >= 1 && i <= BYTE_VALUES) ? CHAR_W'(i - 1) : CHAR_W'(BYTE_VALUES);
      tbl_usage[i] = '0;
    end
    tbl_count = CODE_W'(BYTE_VALUES);
    min_bits = BITS_W'(MIN_BITS_RST);
  endfunction

  // apply one request to the shadow table and return its answer
  function automatic answer_t table_apply(request_t r);
    answer_t a;
    a = '0;
    case (r.req)
      REQ_INSERT: begin
        if (tbl_count >= DEPTH - 1) a.status = ST_FULL;
        else begin
          tbl_count++;
          tbl_prefix[tbl_count] = r.prefix;
          tbl_char[tbl_count] = r.chr;
          tbl_usage[tbl_count] = '0;
          a.code_out = tbl_count;
        end
      end
      REQ_FIND: begin
        for (int c = tbl_count; c >= 1; c--)
          if (tbl_prefix[c] == r.prefix && tbl_char[c] == r.chr) begin
            a.found = 1'b1;
            a.code_out = CODE_W'(c);
            break;
          end
      end
      REQ_READ, REQ_BUMP, REQ_REPLACE: begin
        if (r.code == 0 || r.code > tbl_count) a.status = ST_RANGE;
        else begin
          if (r.req == REQ_BUMP && tbl_usage[r.code] != USE_MAX) tbl_usage[r.code]++;
          if (r.req == REQ_REPLACE) tbl_char[r.code] = r.chr;
          a.prefix_out = tbl_prefix[r.code];
          a.char_out = tbl_char[r.code];
          a.usage_out = tbl_usage[r.code];
        end
      end
      default: ;
    endcase
    a.entry_count = tbl_count;
    a.code_bits = width_of(tbl_count);
    return a;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // send one request; waits for acceptance
  task automatic send_request(request_t r, logic has_ans = 1'b0, answer_t typed = '0);
    answer_t a;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= r.req;
    in_tdata <= {7'd0, r.code, r.chr, r.prefix};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    a = table_apply(r);
    if (has_ans && a != typed) report_mismatch("directed row", 0, 1);
    answers_due.push_back(a);
    @(negedge clk);
  endtask

  task automatic drain(int settle);
    int guard;
    in_tvalid <= 1'b0;
    guard = 0;
    while (answers_due.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_min_bits(logic [BITS_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    min_bits = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver side
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checking
  always @(posedge clk) begin
    answer_t want;
    answer_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.found = out_tdata[0];
      got.code_out = out_tdata[12:1];
      got.prefix_out = out_tdata[24:13];
      got.char_out = out_tdata[33:25];
      got.usage_out = out_tdata[49:34];
      got.entry_count = out_tdata[61:50];
      got.code_bits = out_tdata[65:62];
      got.status = out_tuser;
      if (answers_due.size() == 0) begin
        report_mismatch("unexpected result item", 1, 0);
      end else begin
        want = answers_due.pop_front();
        if (got.found != want.found) report_mismatch("found", got.found, want.found);
        if (got.code_out != want.code_out)
          report_mismatch("code_out", got.code_out, want.code_out);
        if (got.prefix_out != want.prefix_out)
          report_mismatch("prefix_out", got.prefix_out, want.prefix_out);
        if (got.char_out != want.char_out)
          report_mismatch("char_out", got.char_out, want.char_out);
        if (got.usage_out != want.usage_out)
          report_mismatch("usage_out", got.usage_out, want.usage_out);
        if (got.entry_count != want.entry_count)
          report_mismatch("entry_count", got.entry_count, want.entry_count);
        if (got.code_bits != want.code_bits)
          report_mismatch("code_bits", got.code_bits, want.code_bits);
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
      end
    end
  end

  function automatic request_t mk(logic [REQ_W-1:0] q, int p, int ch, int c);
    request_t r;
    r.req = q;
    r.prefix = CODE_W'(p);
    r.chr = CHAR_W'(ch);
    r.code = CODE_W'(c);
    return r;
  endfunction

  function automatic answer_t ans(int cd, int pf, int ch, int st, int cnt, int bits);
    answer_t a;
    a = '0;
    a.code_out = CODE_W'(cd);
    a.found = (cd != 0) && (pf < 0);
    a.prefix_out = (pf < 0) ? '0 : CODE_W'(pf);
    a.char_out = CHAR_W'(ch);
    a.status = STAT_W'(st);
    a.entry_count = CODE_W'(cnt);
    a.code_bits = BITS_W'(bits);
    return a;
  endfunction

  // random request, biased toward the live part of the table
  function automatic request_t rand_request();
    request_t r;
    int k;
    k = $urandom_range(99);
    r.prefix = ($urandom_range(3) == 0) ? CODE_W'($urandom) : CODE_W'($urandom_range(tbl_count));
    r.chr = ($urandom_range(15) == 0) ? CHAR_W'(BYTE_VALUES) : CHAR_W'($urandom_range(255));
    r.code = ($urandom_range(7) == 0) ? CODE_W'($urandom) : CODE_W'($urandom_range(tbl_count));
    if (k < 25) r.req = REQ_INSERT;
    else if (k < 50) begin
      r.req = REQ_FIND;
      // mostly look up pairs that exist
      if (k < 42 && tbl_count > 0) begin
        int c;
        c = $urandom_range(tbl_count, 1);
        r.prefix = tbl_prefix[c];
        r.chr = tbl_char[c];
      end
    end else if (k < 68) r.req = REQ_READ;
    else if (k < 85) r.req = REQ_BUMP;
    else if (k < 97) r.req = REQ_REPLACE;
    else r.req = REQ_W'($urandom_range(7, 5));
    return r;
  endfunction

  row_t rows [$];
  int idle_set [4][2] = '{'{0, 0}, '{57, 0}, '{0, 57}, '{17, 17}};
  logic [BITS_W-1:0] bit_set [4] = '{4'd13, 4'd1, 4'd0, 4'd11};

  initial begin
    table_reset();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, every request kind, error cases
    rows.push_back('{mk(REQ_READ, 0, 0, 1), 1'b1, ans(0, 0, 0, ST_OK, 256, 9)});
    rows.push_back('{mk(REQ_READ, 0, 0, 256), 1'b1, ans(0, 0, 255, ST_OK, 256, 9)});
    rows.push_back('{mk(REQ_READ, 0, 0, 0), 1'b1, ans(0, 0, 0, ST_RANGE, 256, 9)});
    rows.push_back('{mk(REQ_READ, 0, 0, 257), 1'b1, ans(0, 0, 0, ST_RANGE, 256, 9)});
    rows.push_back('{mk(REQ_BUMP, 0, 0, 4095), 1'b1, ans(0, 0, 0, ST_RANGE, 256, 9)});
    rows.push_back('{mk(REQ_REPLACE, 0, 5, 0), 1'b1, ans(0, 0, 0, ST_RANGE, 256, 9)});
    rows.push_back('{mk(REQ_FIND, 0, 65, 0), 1'b1, ans(66, -1, 0, ST_OK, 256, 9)});
    rows.push_back('{mk(REQ_FIND, 4095, 256, 0), 1'b1, ans(0, 0, 0, ST_OK, 256, 9)});
    rows.push_back('{mk(REQ_INSERT, 4095, 256, 4095), 1'b1, ans(257, 0, 0, ST_OK, 257, 9)});
    rows.push_back('{mk(REQ_FIND, 4095, 256, 0), 1'b0, '0});
    rows.push_back('{mk(REQ_INSERT, 0, 65, 0), 1'b0, '0});
    rows.push_back('{mk(REQ_FIND, 0, 65, 0), 1'b0, '0});
    rows.push_back('{mk(REQ_BUMP, 0, 0, 257), 1'b0, '0});
    rows.push_back('{mk(REQ_BUMP, 0, 0, 257), 1'b0, '0});
    rows.push_back('{mk(REQ_REPLACE, 0, 256, 1), 1'b0, '0});
    rows.push_back('{mk(REQ_READ, 0, 0, 1), 1'b0, '0});
    rows.push_back('{mk(REQ_REPLACE, 0, 511, 2), 1'b0, '0});
    rows.push_back('{mk(3'd5, 4095, 511, 4095), 1'b1, ans(0, 0, 0, ST_OK, 258, 9)});
    rows.push_back('{mk(3'd7, 0, 0, 0), 1'b1, ans(0, 0, 0, ST_OK, 258, 9)});
    rows.push_back('{mk(REQ_FIND, 0, 0, 0), 1'b0, '0});
    foreach (rows[i]) send_request(rows[i].rq, rows[i].has_ans, rows[i].ans);
    drain(8);

    // repeated bumps on one byte entry (quick, no idling)
    for (int i = 0; i < 70; i++) send_request(mk(REQ_BUMP, 0, 0, 3));
    drain(8);

    // random phases with different widths and idling
    for (int ph = 0; ph < 4; ph++) begin
      write_min_bits(bit_set[ph]);
      send_idle_pct = idle_set[ph][0];
      recv_stall_pct = idle_set[ph][1];
      if (ph == 1) hold_off = 300;
      for (int i = 0; i < 460; i++) send_request(rand_request());
      drain(8 + tbl_count);
    end

    // top of the code range, then a short random tail
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_min_bits(4'd9);
    send_request(mk(REQ_READ, 0, 0, 4095));
    send_request(mk(REQ_READ, 0, 0, 4094));
    for (int i = 0; i < 20; i++) send_request(rand_request());
    drain(DEPTH + 8);

    if (answers_due.size() == 0 && errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  initial begin
    #500ms;
    $display("tb: FAIL");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/lzwdt_pkg.sv
hw/rtl/lzwdt_ram.sv
hw/rtl/lzw_dictionary_table_unit.sv
verif/tb.sv
